// ===== rtl/field_statistics_reducer_core_assert.svh =====
// Assertion macros shared by the field statistics reducer modules.
`ifndef FIELD_STATISTICS_REDUCER_CORE_ASSERT_SVH
`define FIELD_STATISTICS_REDUCER_CORE_ASSERT_SVH

// Clocked check on clk_i, switched off while rst_ni is low.
`define FRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication check on clk_i, switched off while rst_ni is low.
`define FRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/frs_pkg.sv =====
// Package with the types and constants of the field statistics reducer.
package frs_pkg;

  localparam int unsigned SCORE_W   = 17;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned WALL_W    = 20;
  localparam int unsigned COUNT_W   = 21;
  localparam int unsigned BIN_W     = 3;
  localparam int unsigned NUM_BINS  = 6;
  localparam int unsigned SSUM_W    = 38;
  localparam int unsigned WSUM_W    = 41;
  localparam int unsigned DIV_W     = 41;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [COUNT_W-1:0]   MAX_CELLS     = COUNT_W'(1048576);
  localparam logic [SCORE_W-1:0]   THRESH_RESET  = SCORE_W'(32768);
  localparam logic [BIN_W-1:0]     UNKNOWN_BIN   = BIN_W'(6);
  localparam logic [BIN_W-1:0]     LAST_KNOWN_BIN = BIN_W'(NUM_BINS - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DIV_W - 1);

  typedef struct packed {
    logic [SCORE_W-1:0] cell_score;
    logic [CODE_W-1:0]  factor_code;
    logic [WALL_W-1:0]  wall_um;
    logic               last_cell;
  } cell_t;

  typedef struct packed {
    logic [BIN_W-1:0]   hist_code;
    logic [COUNT_W-1:0] hist_count;
    logic [COUNT_W-1:0] cell_total;
    logic [SCORE_W-1:0] score_low;
    logic [SCORE_W-1:0] score_high;
    logic [SCORE_W-1:0] score_avg;
    logic [WALL_W-1:0]  wall_low;
    logic [WALL_W-1:0]  wall_high;
    logic [WALL_W-1:0]  wall_avg;
    logic [COUNT_W-1:0] below_total;
    logic [BIN_W-1:0]   dominant_code;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic accept_cell;
    logic div_start;
    logic div_wall;
    logic store_score_avg;
    logic store_wall_avg;
    logic latch_dom;
    logic emit_next;
    logic clear_run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_result;
  } dp_sts_t;

endpackage

// ===== rtl/frs_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`include "field_statistics_reducer_core_assert.svh"

module frs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [frs_pkg::DIV_W-1:0]     dividend_i,
  input  logic [frs_pkg::COUNT_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [frs_pkg::DIV_W-1:0]     quotient_o
);
  import frs_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [COUNT_W-1:0]   divisor_q, divisor_d;
  logic [COUNT_W:0]     shifted;
  logic [COUNT_W+1:0]   diff;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_q};

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = DIV_LAST_STEP;
      rem_d     = '0;
      quo_d     = dividend_i;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      if (!diff[COUNT_W+1]) begin
        rem_d = diff[COUNT_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[COUNT_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    divisor_q <= divisor_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `FRS_ASSERT_IMP(a_done_single_pulse, done_q, !done_q, "divider done held longer than a cycle")
  `FRS_ASSERT(a_done_not_busy, !(done_q && busy_q), "divider done while still busy")

endmodule

// ===== rtl/frs_datapath.sv =====
// Datapath: run accumulators, threshold register, histogram and result fields.
`include "field_statistics_reducer_core_assert.svh"

module frs_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  frs_pkg::ctrl_cmd_t          cmd_i,
  output frs_pkg::dp_sts_t            sts_o,
  input  frs_pkg::cell_t              cell_i,
  input  logic                        cfg_write_i,
  input  logic [frs_pkg::SCORE_W-1:0] cfg_wdata_i,
  output frs_pkg::result_t            result_o
);
  import frs_pkg::*;

  logic [SCORE_W-1:0] thresh_q;
  logic [COUNT_W-1:0] cells_seen_q;
  logic [SCORE_W-1:0] min_score_q, max_score_q;
  logic [SSUM_W-1:0]  sum_score_q;
  logic [WALL_W-1:0]  min_wall_q, max_wall_q;
  logic [WSUM_W-1:0]  sum_wall_q;
  logic [COUNT_W-1:0] below_q;
  logic [COUNT_W-1:0] bins_q [NUM_BINS];
  logic [COUNT_W-1:0] unknown_q;
  logic [BIN_W-1:0]   bin_idx_q;
  logic [BIN_W-1:0]   dom_q, dom_d;
  logic [SCORE_W-1:0] score_avg_q;
  logic [WALL_W-1:0]  wall_avg_q;
  logic [COUNT_W-1:0] best_count;
  logic [COUNT_W-1:0] hist_count;
  logic               take;
  logic               first;
  logic               div_done;
  logic [DIV_W-1:0]   quotient;
  logic [DIV_W-1:0]   dividend;
  logic               last_result;

  assign take  = cmd_i.accept_cell && (cells_seen_q < MAX_CELLS);
  assign first = (cells_seen_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_write_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_seen_q <= '0;
      min_score_q  <= '0;
      max_score_q  <= '0;
      sum_score_q  <= '0;
      min_wall_q   <= '0;
      max_wall_q   <= '0;
      sum_wall_q   <= '0;
      below_q      <= '0;
      unknown_q    <= '0;
      bin_idx_q    <= '0;
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_q[i] <= '0;
      end
    end else if (cmd_i.clear_run) begin
      cells_seen_q <= '0;
      min_score_q  <= '0;
      max_score_q  <= '0;
      sum_score_q  <= '0;
      min_wall_q   <= '0;
      max_wall_q   <= '0;
      sum_wall_q   <= '0;
      below_q      <= '0;
      unknown_q    <= '0;
      bin_idx_q    <= '0;
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_q[i] <= '0;
      end
    end else begin
      if (cmd_i.emit_next) begin
        bin_idx_q <= bin_idx_q + 1'b1;
      end
      if (take) begin
        if (first || (cell_i.cell_score < min_score_q)) min_score_q <= cell_i.cell_score;
        if (first || (cell_i.cell_score > max_score_q)) max_score_q <= cell_i.cell_score;
        if (first || (cell_i.wall_um < min_wall_q))     min_wall_q  <= cell_i.wall_um;
        if (first || (cell_i.wall_um > max_wall_q))     max_wall_q  <= cell_i.wall_um;
        sum_score_q  <= sum_score_q + SSUM_W'(cell_i.cell_score);
        sum_wall_q   <= sum_wall_q + WSUM_W'(cell_i.wall_um);
        cells_seen_q <= cells_seen_q + 1'b1;
        if (cell_i.cell_score < thresh_q) begin
          below_q <= below_q + 1'b1;
        end
        if (cell_i.factor_code >= CODE_W'(NUM_BINS)) begin
          unknown_q <= unknown_q + 1'b1;
        end
        for (int i = 0; i < NUM_BINS; i++) begin
          if (cell_i.factor_code == CODE_W'(i)) begin
            bins_q[i] <= bins_q[i] + 1'b1;
          end
        end
      end
    end
  end

  // Dominant factor over codes one to five; a strict compare keeps the lower code on ties.
  always_comb begin
    dom_d      = '0;
    best_count = '0;
    for (int i = 1; i < NUM_BINS; i++) begin
      if (bins_q[i] > best_count) begin
        dom_d      = BIN_W'(i);
        best_count = bins_q[i];
      end
    end
  end

  assign dividend = cmd_i.div_wall ? sum_wall_q : DIV_W'(sum_score_q);

  frs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (cells_seen_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_dom) begin
      dom_q <= dom_d;
    end
    if (cmd_i.store_score_avg) begin
      score_avg_q <= first ? '0 : quotient[SCORE_W-1:0];
    end
    if (cmd_i.store_wall_avg) begin
      wall_avg_q <= first ? '0 : quotient[WALL_W-1:0];
    end
  end

  always_comb begin
    case (bin_idx_q)
      3'd0:    hist_count = bins_q[0];
      3'd1:    hist_count = bins_q[1];
      3'd2:    hist_count = bins_q[2];
      3'd3:    hist_count = bins_q[3];
      3'd4:    hist_count = bins_q[4];
      3'd5:    hist_count = bins_q[5];
      default: hist_count = unknown_q;
    endcase
  end

  assign last_result = (bin_idx_q == UNKNOWN_BIN) ||
                       ((bin_idx_q == LAST_KNOWN_BIN) && (unknown_q == '0));

  assign sts_o.div_done    = div_done;
  assign sts_o.last_result = last_result;

  assign result_o.hist_code     = bin_idx_q;
  assign result_o.hist_count    = hist_count;
  assign result_o.cell_total    = cells_seen_q;
  assign result_o.score_low     = min_score_q;
  assign result_o.score_high    = max_score_q;
  assign result_o.score_avg     = score_avg_q;
  assign result_o.wall_low      = min_wall_q;
  assign result_o.wall_high     = max_wall_q;
  assign result_o.wall_avg      = wall_avg_q;
  assign result_o.below_total   = below_q;
  assign result_o.dominant_code = dom_q;
  assign result_o.last_result   = last_result;

  `FRS_ASSERT(a_cells_capped, cells_seen_q <= MAX_CELLS, "cell count passed capacity")
  `FRS_ASSERT(a_bin_idx_range, bin_idx_q <= UNKNOWN_BIN, "result bin index out of range")

endmodule

// ===== rtl/frs_ctrl.sv =====
// Controller state machine sequencing accumulation, division and result emission.
`include "field_statistics_reducer_core_assert.svh"

module frs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  frs_pkg::dp_sts_t   sts_i,
  output frs_pkg::ctrl_cmd_t cmd_o
);
  import frs_pkg::*;

  typedef enum logic [5:0] {
    ST_ACCUM   = 6'b000001,
    ST_SDIV_GO = 6'b000010,
    ST_SDIV    = 6'b000100,
    ST_WDIV_GO = 6'b001000,
    ST_WDIV    = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   in_take;
  logic   out_take;

  assign in_take  = in_valid_i && (state_q == ST_ACCUM);
  assign out_take = out_ready_i && (state_q == ST_EMIT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACCUM:   if (in_take && in_last_i) state_d = ST_SDIV_GO;
      ST_SDIV_GO: state_d = ST_SDIV;
      ST_SDIV:    if (sts_i.div_done) state_d = ST_WDIV_GO;
      ST_WDIV_GO: state_d = ST_WDIV;
      ST_WDIV:    if (sts_i.div_done) state_d = ST_EMIT;
      ST_EMIT:    if (out_take && sts_i.last_result) state_d = ST_ACCUM;
      default:    state_d = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_ACCUM);
  assign out_valid_o = (state_q == ST_EMIT);

  always_comb begin
    cmd_o                 = '0;
    cmd_o.accept_cell     = in_take;
    cmd_o.div_start       = (state_q == ST_SDIV_GO) || (state_q == ST_WDIV_GO);
    cmd_o.div_wall        = (state_q == ST_WDIV_GO);
    cmd_o.latch_dom       = (state_q == ST_SDIV_GO);
    cmd_o.store_score_avg = (state_q == ST_SDIV) && sts_i.div_done;
    cmd_o.store_wall_avg  = (state_q == ST_WDIV) && sts_i.div_done;
    cmd_o.emit_next       = out_take && !sts_i.last_result;
    cmd_o.clear_run       = out_take && sts_i.last_result;
  end

  `FRS_ASSERT(a_done_in_div, !sts_i.div_done || (state_q == ST_SDIV) || (state_q == ST_WDIV), "divider finished outside a divide phase")
  `FRS_ASSERT_IMP(a_last_starts_div, in_take && in_last_i, state_q == ST_SDIV_GO, "final cell did not start the score division")

endmodule

// ===== rtl/field_statistics_reducer_core.sv =====
// Top level of the field statistics reducer: streaming min, max, mean and histogram.
//
// The block reduces the cells of one field into a run summary. While it is accumulating it
// takes one cell transaction per clock cycle: each cell updates the cell count, the minimum,
// maximum and sum of score and of wall thickness, the count of cells scoring strictly below the
// threshold register, and a histogram over factor codes 0 to 5 with a separate count for codes
// above 5. Cells that arrive once 1048576 cells are held are dropped, but their last-cell mark
// still closes the run. The cell marked last starts the closing phase, during which the input
// is not ready: the dominant factor is latched, then a shared restoring divider forms the floor
// of the score mean and then of the wall mean; each division is loaded in its own start state
// and its quotient is stored when the divider signals done. Six result transactions follow, one
// per histogram bin in code order, and a seventh for unrecognised codes when any were seen;
// each carries the whole summary and the last one is flagged. Results leave one per cycle while
// the output is ready. After the final result has been taken the accumulators clear and the
// next field may start. The threshold is written through the configuration channel, which is
// always ready; it should only be written while no field is in progress.
module field_statistics_reducer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  frs_pkg::cell_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output frs_pkg::result_t            out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [frs_pkg::SCORE_W-1:0] cfg_wdata_i
);
  import frs_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // The threshold register can be written in any cycle.
  assign cfg_ready_o = 1'b1;

  frs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_cell),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  frs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cell_i      (in_data_i),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (out_data_o)
  );

endmodule

// ===== sim/field_statistics_reducer_core_test.sv =====
// Self-checking testbench for the field statistics reducer core.

// Holds a bit-accurate copy of the run summary and the results it expects next.
class field_summary_model;
  bit [frs_pkg::SCORE_W-1:0] threshold;
  bit [frs_pkg::COUNT_W-1:0] cells_seen;
  bit [frs_pkg::SCORE_W-1:0] min_score;
  bit [frs_pkg::SCORE_W-1:0] max_score;
  bit [frs_pkg::SSUM_W-1:0]  sum_score;
  bit [frs_pkg::WALL_W-1:0]  min_wall;
  bit [frs_pkg::WALL_W-1:0]  max_wall;
  bit [frs_pkg::WSUM_W-1:0]  sum_wall;
  bit [frs_pkg::COUNT_W-1:0] below_count;
  bit [frs_pkg::COUNT_W-1:0] bin_counts [frs_pkg::NUM_BINS];
  bit [frs_pkg::COUNT_W-1:0] unknown_count;
  frs_pkg::result_t          expected_summaries [$];
  int unsigned               summary_mismatches;

  function new();
    threshold = frs_pkg::THRESH_RESET;
    summary_mismatches = 0;
    clear_run();
  endfunction

  function void clear_run();
    cells_seen = '0;
    min_score = '0;
    max_score = '0;
    sum_score = '0;
    min_wall = '0;
    max_wall = '0;
    sum_wall = '0;
    below_count = '0;
    unknown_count = '0;
    foreach (bin_counts[i]) bin_counts[i] = '0;
  endfunction

  // Folds one accepted cell into the summary; the last cell of a field queues its results.
  function void accumulate_cell(frs_pkg::cell_t c);
    bit [frs_pkg::BIN_W-1:0]   dom;
    bit [frs_pkg::COUNT_W-1:0] dom_count;
    frs_pkg::result_t          r;
    if (cells_seen < frs_pkg::MAX_CELLS) begin
      if (cells_seen == 0) begin
        min_score = c.cell_score;
        max_score = c.cell_score;
        min_wall = c.wall_um;
        max_wall = c.wall_um;
      end else begin
        if (c.cell_score < min_score) min_score = c.cell_score;
        if (c.cell_score > max_score) max_score = c.cell_score;
        if (c.wall_um < min_wall) min_wall = c.wall_um;
        if (c.wall_um > max_wall) max_wall = c.wall_um;
      end
      sum_score += frs_pkg::SSUM_W'(c.cell_score);
      sum_wall += frs_pkg::WSUM_W'(c.wall_um);
      if (c.cell_score < threshold) below_count++;
      if (c.factor_code < frs_pkg::NUM_BINS) bin_counts[c.factor_code[frs_pkg::BIN_W-1:0]]++;
      else unknown_count++;
      cells_seen++;
    end
    if (!c.last_cell) return;

    // Dominant factor ignores bin 0; a strict greater-than keeps the lower code on ties.
    dom = '0;
    dom_count = '0;
    for (int i = 1; i < frs_pkg::NUM_BINS; i++) begin
      if (bin_counts[i] > dom_count) begin
        dom = frs_pkg::BIN_W'(i);
        dom_count = bin_counts[i];
      end
    end
    r = '0;
    r.cell_total = cells_seen;
    r.score_low = min_score;
    r.score_high = max_score;
    r.wall_low = min_wall;
    r.wall_high = max_wall;
    r.below_total = below_count;
    r.dominant_code = dom;
    if (cells_seen != 0) begin
      r.score_avg = frs_pkg::SCORE_W'(sum_score / cells_seen);
      r.wall_avg = frs_pkg::WALL_W'(sum_wall / cells_seen);
    end
    for (int i = 0; i < frs_pkg::NUM_BINS; i++) begin
      r.hist_code = frs_pkg::BIN_W'(i);
      r.hist_count = bin_counts[i];
      r.last_result = (i == frs_pkg::NUM_BINS - 1) && (unknown_count == 0);
      expected_summaries.push_back(r);
    end
    if (unknown_count != 0) begin
      r.hist_code = frs_pkg::UNKNOWN_BIN;
      r.hist_count = unknown_count;
      r.last_result = 1'b1;
      expected_summaries.push_back(r);
    end
    clear_run();
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      summary_mismatches++;
    end
  endfunction

  function void check_summary(frs_pkg::result_t got);
    frs_pkg::result_t want;
    if (expected_summaries.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %h", $time, got);
      summary_mismatches++;
      return;
    end
    want = expected_summaries.pop_front();
    compare_field("hist_code", 64'(want.hist_code), 64'(got.hist_code));
    compare_field("hist_count", 64'(want.hist_count), 64'(got.hist_count));
    compare_field("cell_total", 64'(want.cell_total), 64'(got.cell_total));
    compare_field("score_low", 64'(want.score_low), 64'(got.score_low));
    compare_field("score_high", 64'(want.score_high), 64'(got.score_high));
    compare_field("score_avg", 64'(want.score_avg), 64'(got.score_avg));
    compare_field("wall_low", 64'(want.wall_low), 64'(got.wall_low));
    compare_field("wall_high", 64'(want.wall_high), 64'(got.wall_high));
    compare_field("wall_avg", 64'(want.wall_avg), 64'(got.wall_avg));
    compare_field("below_total", 64'(want.below_total), 64'(got.below_total));
    compare_field("dominant_code", 64'(want.dominant_code), 64'(got.dominant_code));
    compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
  endfunction
endclass

module field_statistics_reducer_core_test;
  import frs_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  cell_t               in_data_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  result_t             out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [SCORE_W-1:0]  cfg_wdata_i;

  field_summary_model  field_summary;

  // When set, the sender or the receiver runs without any idle cycles.
  bit                  tx_steady;
  bit                  rx_steady = 1'b0;
  int unsigned         rx_hold = 0;
  int unsigned         rx_pick;
  int unsigned         random_cells;

  field_statistics_reducer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Every result transaction is checked against the oldest expectation at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) field_summary.check_summary(out_data_o);
  end

  // Receiver back-pressure: mostly short stalls, a few long ones, and quiet stretches in
  // which the output is always ready. The mode flips now and then so that stalls land on
  // every result of a field as well as on the closing divide.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) rx_steady <= !rx_steady;
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (!rx_steady && rx_pick < 12) begin
        rx_hold <= $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else if (!rx_steady && rx_pick < 15) begin
        rx_hold <= $urandom_range(15, 50);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Idle cycles before the next cell: none in a steady stretch, otherwise mostly short.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cell_t make_cell(int unsigned score, int unsigned code,
                                      int unsigned wall, bit last);
    cell_t c;
    c.cell_score = SCORE_W'(score);
    c.factor_code = CODE_W'(code);
    c.wall_um = WALL_W'(wall);
    c.last_cell = last;
    return c;
  endfunction

  // Random cell: scores cluster around the threshold and the extremes, codes are mostly
  // recognised, walls cover both ends of the range as well as the full span.
  function automatic cell_t random_cell(bit last);
    int          s;
    int unsigned sel;
    int unsigned code;
    int unsigned wall;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      s = int'(field_summary.threshold) + int'($urandom_range(0, 4)) - 2;
      if (s < 0) s = 0;
      if (s > 131071) s = 131071;
    end else if (sel < 35) begin
      case ($urandom_range(0, 2))
        0: s = 0;
        1: s = 65536;
        default: s = 131071;
      endcase
    end else if (sel < 45) begin
      s = $urandom_range(0, 131071);
    end else begin
      s = $urandom_range(0, 65536);
    end
    code = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5) : $urandom_range(6, 255);
    sel = $urandom_range(0, 99);
    if (sel < 20) wall = $urandom_range(0, 15);
    else if (sel < 30) wall = 1048575 - $urandom_range(0, 15);
    else wall = $urandom_range(0, 1048575);
    return make_cell(s, code, wall, last);
  endfunction

  // One cell transaction. Valid rises at a falling edge and is held until accepted; a
  // following cell with no gap keeps valid high, so valid is never lowered and raised at once.
  task automatic send_cell(input cell_t c, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    field_summary.accumulate_cell(c);
  endtask

  // Stops the input, waits for every expected result and then for the closing latency, so
  // that the block is idle and may take a threshold write.
  task automatic drain_and_settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (field_summary.expected_summaries.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [SCORE_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    field_summary.threshold = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned field_len;

    field_summary = new();
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_wdata_i = '0;
    tx_steady = 1'b0;
    random_cells = 0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, first with the threshold at its reset value of one half.
    // A single-cell field: that cell sets every minimum and maximum, and a score equal to
    // the threshold is not counted as below it.
    send_cell(make_cell(32768, 3, 1234, 1'b1), pick_gap());

    // Extremes of every field, unrecognised codes at both ends of their range, and a tie
    // between codes 2 and 4 that must resolve to the lower code.
    send_cell(make_cell(0, 0, 0, 1'b0), pick_gap());
    send_cell(make_cell(131071, 255, 1048575, 1'b0), pick_gap());
    send_cell(make_cell(65536, 6, 1, 1'b0), pick_gap());
    send_cell(make_cell(32767, 1, 524288, 1'b0), pick_gap());
    send_cell(make_cell(1, 2, 7, 1'b0), pick_gap());
    send_cell(make_cell(40000, 4, 99, 1'b0), pick_gap());
    send_cell(make_cell(2, 5, 100, 1'b0), pick_gap());
    send_cell(make_cell(3, 2, 5, 1'b0), pick_gap());
    send_cell(make_cell(4, 4, 8, 1'b1), pick_gap());

    // Only bin 0 populated, so there is no dominant factor.
    send_cell(make_cell(100, 0, 10, 1'b0), pick_gap());
    send_cell(make_cell(200, 0, 20, 1'b1), pick_gap());

    // Threshold at zero: nothing can be below it.
    drain_and_settle();
    write_threshold(SCORE_W'(0));
    send_cell(make_cell(0, 5, 3, 1'b1), pick_gap());

    // Threshold above one: scores beyond the nominal range are compared as given.
    drain_and_settle();
    write_threshold(SCORE_W'(131071));
    send_cell(make_cell(131070, 1, 77, 1'b0), pick_gap());
    send_cell(make_cell(131071, 7, 78, 1'b1), pick_gap());

    // Threshold at exactly one.
    drain_and_settle();
    write_threshold(SCORE_W'(65536));
    send_cell(make_cell(65535, 1, 500, 1'b0), pick_gap());
    send_cell(make_cell(65536, 1, 400, 1'b1), pick_gap());

    // Random fields, mostly short with the odd long one; about a third of them start with a
    // new threshold, the extremes among the choices.
    while (random_cells < 320) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_and_settle();
        case ($urandom_range(0, 5))
          0: write_threshold(SCORE_W'(0));
          1: write_threshold(SCORE_W'(65536));
          2: write_threshold(SCORE_W'(131071));
          default: write_threshold(SCORE_W'($urandom_range(0, 65536)));
        endcase
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0: field_len = $urandom_range(41, 80);
        1, 2, 3, 4: field_len = $urandom_range(13, 40);
        default: field_len = $urandom_range(1, 12);
      endcase
      for (int i = 0; i < field_len; i++) begin
        send_cell(random_cell(i == field_len - 1), pick_gap());
        random_cells++;
      end
    end

    drain_and_settle();
    if (field_summary.summary_mismatches == 0 &&
        field_summary.expected_summaries.size() == 0) begin
      $display("field_statistics_reducer_core_test: clean");
    end else begin
      $display("field_statistics_reducer_core_test: errors");
    end
    $finish;
  end

  // Watchdog, several times the longest correct run with every field closing under long
  // receiver stalls.
  initial begin
    #(64'd5_000_000);
    $display("field_statistics_reducer_core_test: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/frs_pkg.sv
rtl/frs_div.sv
rtl/frs_datapath.sv
rtl/frs_ctrl.sv
rtl/field_statistics_reducer_core.sv
sim/field_statistics_reducer_core_test.sv
